@@ hdl/msl_pkg.sv @@
package msl_pkg;

  // Width of the result position field
  localparam int unsigned POS_W = 6;

  // One input word
  typedef struct packed {
    logic signed [31:0] value;
    logic               end_of_set;
  } in_item_t;

  // One result word
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic [POS_W-1:0]   position;
    logic               final_res;
    logic               overflowed;
  } out_item_t;

  // Handoff from front queue to back
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_head_t;

  // Back-end state
  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } back_state_t;

endpackage

@@ hdl/merge_sort_two_lists.sv @@
// Sorts every stored word of a set into ascending signed order. Words enter one
// per cycle, while full is low and the row is loading, through a two-entry queue
// into an insertion row of CAPACITY cells that keeps its contents sorted. The
// word flagged end_of_set is stored too if the row has room, and then the whole
// row drains, one result word per cycle while pop is held, from position 0
// upward, with final_res on the last one. While draining, the queue still takes
// up to two new words before full rises. Words that find the row full are
// dropped and flagged through overflowed on every result of that set.
module merge_sort_two_lists
  import msl_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  q_head_t head;
  logic    take;

  msl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .head    (head),
    .take    (take)
  );

  msl_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .take     (take),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

@@ hdl/msl_front.sv @@
module msl_front
  import msl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  output q_head_t  head,
  input  logic     take
);

  // Two-entry queue between the input port and the sorting row
  in_item_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = take && (count_r != 2'd0);

  // Present the oldest word to the back end
  assign head.valid = (count_r != 2'd0);
  assign head.item  = slot_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

@@ hdl/msl_back.sv @@
module msl_back
  import msl_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   head,
  output logic      take,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = $clog2(CAPACITY);

  back_state_t        state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic               ovf_r, ovf_nxt;
  logic signed [31:0] cell_r   [CAPACITY];
  logic signed [31:0] cell_nxt [CAPACITY];
  logic [CAPACITY-1:0] le;
  logic               store_full;
  logic               insert;
  logic               shift_out;
  logic signed [31:0] v;

  assign v          = head.item.value;
  assign store_full = (count_r == CW'(CAPACITY));
  assign take       = (state_r == ST_LOAD) && head.valid;
  assign insert     = take && !store_full;
  assign empty      = (state_r != ST_DRAIN);
  assign shift_out  = !empty && pop;

  // Present the head cell of the sorted row
  assign out_data.sorted_value = cell_r[0];
  assign out_data.position     = POS_W'(pos_r);
  assign out_data.final_res    = (count_r == CW'(1));
  assign out_data.overflowed   = ovf_r;

  // Compare each cell against the incoming word
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le[i] = (cell_r[i] <= v);
    end
  end

  // Insert into the row, or shift it down while draining
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
      if (insert) begin
        if ((CW'(i) == count_r) || ((CW'(i) < count_r) && !le[i])) begin
          if (i == 0) begin
            cell_nxt[i] = v;
          end else if (le[(i == 0) ? 0 : i - 1]) begin
            cell_nxt[i] = v;
          end else begin
            cell_nxt[i] = cell_r[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (shift_out && (i < CAPACITY - 1)) begin
        cell_nxt[i] = cell_r[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  // Sequence load and drain
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_LOAD: begin
        if (take) begin
          if (store_full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CW'(1);
          end
          if (head.item.end_of_set) begin
            state_nxt = ST_DRAIN;
            pos_nxt   = '0;
          end
        end
      end
      ST_DRAIN: begin
        if (pop) begin
          count_nxt = count_r - CW'(1);
          pos_nxt   = pos_r + PW'(1);
          if (count_r == CW'(1)) begin
            state_nxt = ST_LOAD;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      pos_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Hold the row contents
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

endmodule

@@ tb/tb_merge_sort_two_lists.sv @@
`timescale 1ns / 100ps

module tb_merge_sort_two_lists;
  import msl_pkg::*;

  localparam int unsigned ROW_DEPTH   = 64;
  localparam int unsigned MAX_GAP     = 14;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_GUARD = 2 * ROW_DEPTH + 16;

  typedef logic signed [31:0] word_t;
  typedef word_t word_list_t[$];

  logic      clk = 1'b0;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_data;
  logic      empty;
  logic      pop;
  out_item_t out_data;

  // Copy of the sorted row and the expected result words
  word_t     model_row[$];
  bit        model_dropped = 1'b0;
  out_item_t pending_sorted[$];

  // Idle and stall controls for the two sides
  bit          send_idle = 1'b0;
  bit          recv_idle = 1'b0;
  int unsigned hold_pop_cycles = 0;

  int unsigned err_cnt = 0;
  int unsigned words_sent = 0;
  int unsigned sets_sent = 0;
  int unsigned results_checked = 0;
  int unsigned dropped_sets = 0;

  merge_sort_two_lists #(
    .CAPACITY(ROW_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Insert one accepted word into the row copy if it has room; on end of set, emit the run
  function automatic void predict_word(input word_t v, input logic eos);
    int        slot;
    int        k;
    out_item_t res;
    if (model_row.size() < ROW_DEPTH) begin
      // place after any equal values already stored
      slot = 0;
      while (slot < model_row.size() && model_row[slot] <= v) slot++;
      model_row.insert(slot, v);
    end else begin
      model_dropped = 1'b1;
    end
    if (eos) begin
      for (k = 0; k < model_row.size(); k++) begin
        res.sorted_value = model_row[k];
        res.position     = POS_W'(k);
        res.final_res    = (k == model_row.size() - 1);
        res.overflowed   = model_dropped;
        pending_sorted.push_back(res);
      end
      if (model_dropped) dropped_sets++;
      sets_sent++;
      model_row.delete();
      model_dropped = 1'b0;
    end
  endfunction

  // Mix of extremes, small values for duplicates, and full-range values
  function automatic word_t draw_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return word_t'(int'($urandom_range(0, 16)) - 8);
      default: return word_t'($urandom());
    endcase
  endfunction

  // Offer one word, hold it until accepted, then predict
  task automatic send_word(input word_t v, input logic eos);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= '{value: v, end_of_set: eos};
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
    predict_word(v, eos);
  endtask

  // Send a whole set, end flag on the last word
  task automatic send_list(input word_list_t vals);
    foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_random_set(input int unsigned n);
    word_list_t vals;
    repeat (n) vals.push_back(draw_value());
    send_list(vals);
  endtask

  // Two sets of one word each, end flag on the first word
  task automatic test_single_word();
    word_list_t vals;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    vals = '{-1};
    send_list(vals);
    vals = '{32'sh7FFF_FFFF};
    send_list(vals);
  endtask

  // Signed extremes and neighbors around zero
  task automatic test_extremes();
    word_list_t vals;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 32'sh8000_0001, 32'sh7FFF_FFFE};
    send_list(vals);
  endtask

  // Repeated values must all come out, in order
  task automatic test_duplicates();
    word_list_t vals;
    send_idle = 1'b0;
    recv_idle = 1'b1;
    vals = '{5, -3, 5, 5, -3, 0, 5, 32'sh8000_0000, 32'sh8000_0000};
    send_list(vals);
  endtask

  // Fill the row, then one more; the end word is itself dropped but still drains it
  task automatic test_overflow();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_random_set(ROW_DEPTH + 1);
  endtask

  // Stall the result side while input keeps coming, so full rises
  task automatic test_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_pop_cycles = HOLD_CYCLES;
    send_random_set(6);
    send_random_set(6);
  endtask

  // Short sets with a random idle mix
  task automatic test_random_sets();
    int unsigned start;
    int unsigned n;
    start = words_sent;
    while (words_sent - start < 10) begin
      {recv_idle, send_idle} = 2'($urandom_range(0, 3));
      n = $urandom_range(1, 5);
      send_random_set(n);
    end
  endtask

  // Pop results and compare against the oldest expectation
  initial begin : result_checker
    int unsigned wait_n;
    out_item_t   want;
    pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      wait_n = hold_pop_cycles + (recv_idle ? $urandom_range(0, MAX_GAP) : 0);
      hold_pop_cycles = 0;
      if (wait_n > 0) begin
        pop <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      results_checked++;
      if (pending_sorted.size() == 0) begin
        $error("result word with nothing expected: sorted_value %0d position %0d",
               out_data.sorted_value, out_data.position);
        err_cnt++;
      end else begin
        want = pending_sorted.pop_front();
        if (out_data.sorted_value !== want.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                 out_data.sorted_value);
          err_cnt++;
        end
        if (out_data.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_data.position);
          err_cnt++;
        end
        if (out_data.final_res !== want.final_res) begin
          $error("final_res: expected %0b, got %0b", want.final_res, out_data.final_res);
          err_cnt++;
        end
        if (out_data.overflowed !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed,
                 out_data.overflowed);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n   <= 1'b0;
    push    <= 1'b0;
    in_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_word();
    test_extremes();
    test_duplicates();
    test_overflow();
    test_backpressure();
    test_random_sets();

    // drain everything, then watch for stray words
    push <= 1'b0;
    recv_idle = 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_GUARD) @(posedge clk);

    $display("Pushed %0d words in %0d sets and checked %0d sorted words.",
             words_sent, sets_sent, results_checked);
    $display("Covered signed extremes, duplicates, a full row, %0d overrun sets and a long stall.",
             dropped_sets);
    if (err_cnt == 0 && pending_sorted.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ merge_sort_two_lists.f @@
hdl/msl_pkg.sv
hdl/msl_front.sv
hdl/msl_back.sv
hdl/merge_sort_two_lists.sv
tb/tb_merge_sort_two_lists.sv
